FILE: hw/rtl/trwm_pkg.sv
package trwm_pkg;

  localparam int DATA_W  = 32;
  localparam int TOK_W   = 16;
  localparam int WS_W    = 16;
  localparam int PID_W   = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 2;
  localparam int CNT_W   = $clog2(DATA_W);
  localparam int MASK_SEL_W = $clog2(DATA_W);
  localparam int STAMP_DEPTH_DEF = 16;

  localparam logic [WS_W-1:0] WS_RESET = WS_W'(100);

  typedef enum logic [KIND_W-1:0] {
    KIND_WORK  = 2'd0,
    KIND_IDLE  = 2'd1,
    KIND_STAMP = 2'd2
  } kind_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_LIFE   = 2'd1,
    CFG_WSTEPS = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PASS = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic add_tok;
    logic shift;
    logic first;
    logic inc_idle;
    logic clr_idle;
    logic commit;
    logic life_load;
  } ctl_t;

endpackage

FILE: hw/rtl/trwm_ram.sv
module trwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/trwm_div.sv
module trwm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [trwm_pkg::DATA_W-1:0]   dividend,
  input  logic [trwm_pkg::DATA_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [trwm_pkg::DATA_W-1:0]   quot
);

  localparam int W = trwm_pkg::DATA_W;

  logic                        busy_r;
  logic                        done_r;
  logic [trwm_pkg::CNT_W-1:0]  cnt_r;
  logic [W-1:0]                rem_r;
  logic [W-1:0]                q_r;
  logic [W-1:0]                dvs_r;
  logic [W:0]                  trial;
  logic [W:0]                  diff;

  assign trial = {rem_r, q_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == trwm_pkg::CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        q_r   <= {q_r[W-2:0], 1'b1};
      end else begin
        rem_r <= trial[W-1:0];
        q_r   <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hw/rtl/trwm_bitpath.sv
module trwm_bitpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trwm_pkg::ctl_t                ctl,
  input  logic [trwm_pkg::TOK_W-1:0]    tok,
  input  logic [trwm_pkg::WS_W-1:0]     wsteps,
  input  logic [trwm_pkg::DATA_W-1:0]   life_val,
  input  logic [trwm_pkg::DATA_W-1:0]   pct_val,
  output logic                          ge,
  output logic [trwm_pkg::DATA_W-1:0]   step_w,
  output logic [trwm_pkg::DATA_W-1:0]   boot_w,
  output logic [trwm_pkg::DATA_W-1:0]   life_w,
  output logic [trwm_pkg::DATA_W-1:0]   lwt_w,
  output logic [trwm_pkg::DATA_W-1:0]   trend_w,
  output logic [trwm_pkg::DATA_W-1:0]   pct_w,
  output logic [trwm_pkg::DATA_W-1:0]   dvd_w,
  output logic [trwm_pkg::DATA_W-1:0]   dvs_w
);

  localparam int W = trwm_pkg::DATA_W;

  logic [W-1:0] step_r, boot_r, life_r, idle_r;
  logic [W-1:0] wss_r, wst_r, lwt_r, trend_r, pct_r;
  logic [W-1:0] win_r, wtok_r, trd_r, prod_r, tok_r, ws_r;
  logic         cs_r, cb_r, cl_r, ci_r, bw_r, bc_r, bt_r, br_r, nz_r;
  logic [1:0]   pc_r;
  logic [5:0]   hist_r;

  logic         cs_i, cb_i, cl_i, ci_i, bw_i, bc_i, bt_i, br_i, nz_i;
  logic [1:0]   pc_i;
  logic [5:0]   hist_i;
  logic         tb, wsb;
  logic         step_nb, boot_nb, life_nb, idle_nb, w_nb, wt_nb, tr_nb;
  logic         cs_nxt, cb_nxt, cl_nxt, ci_nxt, bw_nxt, bc_nxt, bt_nxt, br_nxt;
  logic [2:0]   psum;

  always_comb begin
    cs_i   = ctl.first ? 1'b1 : cs_r;
    cb_i   = ctl.first ? 1'b0 : cb_r;
    cl_i   = ctl.first ? 1'b0 : cl_r;
    ci_i   = ctl.first ? ctl.inc_idle : ci_r;
    bw_i   = ctl.first ? 1'b0 : bw_r;
    bc_i   = ctl.first ? 1'b0 : bc_r;
    bt_i   = ctl.first ? 1'b0 : bt_r;
    br_i   = ctl.first ? 1'b0 : br_r;
    nz_i   = ctl.first ? 1'b0 : nz_r;
    pc_i   = ctl.first ? 2'b00 : pc_r;
    hist_i = ctl.first ? 6'b0 : hist_r;

    tb  = tok_r[0];
    wsb = ws_r[0];

    step_nb = step_r[0] ^ cs_i;
    cs_nxt  = step_r[0] & cs_i;

    boot_nb = boot_r[0] ^ tb ^ cb_i;
    cb_nxt  = (boot_r[0] & tb) | (boot_r[0] & cb_i) | (tb & cb_i);

    life_nb = life_r[0] ^ tb ^ cl_i;
    cl_nxt  = (life_r[0] & tb) | (life_r[0] & cl_i) | (tb & cl_i);

    idle_nb = ctl.clr_idle ? 1'b0 : (idle_r[0] ^ ci_i);
    ci_nxt  = idle_r[0] & ci_i;

    w_nb   = step_nb ^ wss_r[0] ^ bw_i;
    bw_nxt = (~step_nb & wss_r[0]) | (~(step_nb ^ wss_r[0]) & bw_i);

    bc_nxt = (~w_nb & wsb) | (~(w_nb ^ wsb) & bc_i);

    wt_nb  = boot_nb ^ wst_r[0] ^ bt_i;
    bt_nxt = (~boot_nb & wst_r[0]) | (~(boot_nb ^ wst_r[0]) & bt_i);

    tr_nb  = wt_nb ^ lwt_r[0] ^ br_i;
    br_nxt = (~wt_nb & lwt_r[0]) | (~(wt_nb ^ lwt_r[0]) & br_i);

    psum = {2'b00, hist_i[1]} + {2'b00, hist_i[4]} + {2'b00, hist_i[5]} + {1'b0, pc_i};
  end

  assign ge = ~bc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      boot_r  <= '0;
      life_r  <= '0;
      idle_r  <= '0;
      wss_r   <= '0;
      wst_r   <= '0;
      lwt_r   <= '0;
      trend_r <= '0;
      pct_r   <= '0;
    end else if (ctl.shift) begin
      step_r <= {step_nb, step_r[W-1:1]};
      boot_r <= {boot_nb, boot_r[W-1:1]};
      life_r <= {life_nb, life_r[W-1:1]};
      idle_r <= {idle_nb, idle_r[W-1:1]};
      wss_r  <= {wss_r[0], wss_r[W-1:1]};
      wst_r  <= {wst_r[0], wst_r[W-1:1]};
      lwt_r  <= {lwt_r[0], lwt_r[W-1:1]};
    end else if (ctl.commit) begin
      wss_r   <= step_r;
      wst_r   <= boot_r;
      lwt_r   <= wtok_r;
      trend_r <= trd_r;
      pct_r   <= pct_val;
    end else if (ctl.life_load) begin
      life_r <= life_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tok_r <= ctl.add_tok ? {{(W - trwm_pkg::TOK_W){1'b0}}, tok} : '0;
      ws_r  <= {{(W - trwm_pkg::WS_W){1'b0}}, wsteps};
    end else if (ctl.shift) begin
      tok_r  <= {1'b0, tok_r[W-1:1]};
      ws_r   <= {1'b0, ws_r[W-1:1]};
      win_r  <= {w_nb, win_r[W-1:1]};
      wtok_r <= {wt_nb, wtok_r[W-1:1]};
      trd_r  <= {tr_nb, trd_r[W-1:1]};
      prod_r <= {psum[0], prod_r[W-1:1]};
      cs_r   <= cs_nxt;
      cb_r   <= cb_nxt;
      cl_r   <= cl_nxt;
      ci_r   <= ci_nxt;
      bw_r   <= bw_nxt;
      bc_r   <= bc_nxt;
      bt_r   <= bt_nxt;
      br_r   <= br_nxt;
      nz_r   <= nz_i | w_nb;
      pc_r   <= psum[2:1];
      hist_r <= {hist_i[4:0], idle_nb};
    end
  end

  assign step_w  = step_r;
  assign boot_w  = boot_r;
  assign life_w  = life_r;
  assign lwt_w   = lwt_r;
  assign trend_w = trend_r;
  assign pct_w   = pct_r;
  assign dvd_w   = prod_r;
  assign dvs_w   = nz_r ? win_r : W'(1);

endmodule

FILE: hw/rtl/token_rate_window_monitor_unit.sv
// Token rate window monitor. Each word on the input channel is a work step, an idle step
// or a phase stamp; each accepted word yields exactly one result word showing the counters
// after the event. Counter updates run LSB first through 32-bit shift registers with
// one-bit adders, so a work or idle step is accepted, passes serially through the shift
// registers and then goes to the result register. A work step that closes a window also
// runs the one-bit-per-cycle restoring divider that forms the idle percent before its
// result is registered. Stamps, kind three and words taken while disabled skip the serial pass. A new word
// is accepted as soon as the previous one has reached the output register. Configuration
// writes are taken only while no word is in progress; writing lifetime_start loads the
// lifetime counter. Phase stamps are kept in a STAMP_DEPTH entry table; once it is
// full, further stamps are dropped and leave the phase mask unchanged.
module token_rate_window_monitor_unit #(
  parameter int STAMP_DEPTH = trwm_pkg::STAMP_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [trwm_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [trwm_pkg::TOK_W-1:0]    in_tokens,
  input  logic [trwm_pkg::PID_W-1:0]           in_phase_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [trwm_pkg::DATA_W-1:0]          out_steps_count,
  output logic [trwm_pkg::DATA_W-1:0]          out_boot_tokens,
  output logic [trwm_pkg::DATA_W-1:0]          out_life_tokens,
  output logic [trwm_pkg::DATA_W-1:0]          out_window_tokens,
  output logic signed [trwm_pkg::DATA_W-1:0]   out_window_trend,
  output logic [trwm_pkg::DATA_W-1:0]          out_idle_percent,
  output logic [trwm_pkg::DATA_W-1:0]          out_phase_mask,
  output logic                                 out_window_closed,
  output logic                                 out_stamp_taken,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [trwm_pkg::CFG_W-1:0]           cfg_index,
  input  logic [trwm_pkg::DATA_W-1:0]          cfg_data
);

  localparam int W      = trwm_pkg::DATA_W;
  localparam int FILL_W = $clog2(STAMP_DEPTH + 1);
  localparam int ADDR_W = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;
  localparam int RAM_W  = trwm_pkg::PID_W + W;

  trwm_pkg::state_t              state_r, state_nxt;
  trwm_pkg::ctl_t                ctl;

  logic                          enable_r;
  logic [trwm_pkg::WS_W-1:0]     wsteps_r;
  logic [trwm_pkg::CNT_W-1:0]    cnt_r;
  logic                          work_r, inc_r, clr_r;
  logic                          closed_r, taken_r;
  logic                          div_start_r;
  logic [FILL_W-1:0]             fill_r;
  logic [W-1:0]                  mask_r;

  logic                          out_valid_r;
  logic [W-1:0]                  o_step_r, o_boot_r, o_life_r, o_lwt_r;
  logic [W-1:0]                  o_trend_r, o_pct_r, o_mask_r;
  logic                          o_closed_r, o_taken_r;

  logic                          in_acc, cfg_acc, tok_pos, stamp_we, last_bit, out_load;
  logic                          ge;
  logic                          div_busy, div_done;
  logic [W-1:0]                  div_quot;
  logic [W-1:0]                  step_w, boot_w, life_w, lwt_w, trend_w, pct_w, dvd_w, dvs_w;

  assign in_stall  = (state_r != trwm_pkg::ST_IDLE);
  assign cfg_ready = (state_r == trwm_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign tok_pos   = !in_tokens[trwm_pkg::TOK_W-1] && (in_tokens != '0);
  assign last_bit  = (cnt_r == trwm_pkg::CNT_W'(W - 1));
  assign stamp_we  = in_acc && enable_r && (in_kind == trwm_pkg::KIND_STAMP)
                     && (fill_r < FILL_W'(STAMP_DEPTH));
  assign out_load  = (state_r == trwm_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    ctl           = '0;
    ctl.load      = in_acc;
    ctl.add_tok   = tok_pos && (in_kind == trwm_pkg::KIND_WORK);
    ctl.shift     = (state_r == trwm_pkg::ST_PASS);
    ctl.first     = (state_r == trwm_pkg::ST_PASS) && (cnt_r == '0);
    ctl.inc_idle  = inc_r;
    ctl.clr_idle  = clr_r;
    ctl.commit    = (state_r == trwm_pkg::ST_DIV) && div_done;
    ctl.life_load = cfg_acc && (cfg_index == trwm_pkg::CFG_LIFE);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trwm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (enable_r && ((in_kind == trwm_pkg::KIND_WORK) ||
                           (in_kind == trwm_pkg::KIND_IDLE))) begin
            state_nxt = trwm_pkg::ST_PASS;
          end else begin
            state_nxt = trwm_pkg::ST_DONE;
          end
        end
      end
      trwm_pkg::ST_PASS: begin
        if (last_bit) begin
          state_nxt = (work_r && ge) ? trwm_pkg::ST_DIV : trwm_pkg::ST_DONE;
        end
      end
      trwm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = trwm_pkg::ST_DONE;
        end
      end
      trwm_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = trwm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trwm_pkg::ST_IDLE;
      enable_r    <= 1'b1;
      wsteps_r    <= trwm_pkg::WS_RESET;
      cnt_r       <= '0;
      work_r      <= 1'b0;
      inc_r       <= 1'b0;
      clr_r       <= 1'b0;
      closed_r    <= 1'b0;
      taken_r     <= 1'b0;
      div_start_r <= 1'b0;
      fill_r      <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= (state_r == trwm_pkg::ST_PASS) && last_bit && work_r && ge;
      if (cfg_acc) begin
        unique case (cfg_index)
          trwm_pkg::CFG_ENABLE: enable_r <= cfg_data[0];
          trwm_pkg::CFG_WSTEPS: wsteps_r <= cfg_data[trwm_pkg::WS_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        cnt_r    <= '0;
        work_r   <= (in_kind == trwm_pkg::KIND_WORK);
        inc_r    <= (in_kind == trwm_pkg::KIND_IDLE);
        clr_r    <= tok_pos && (in_kind == trwm_pkg::KIND_WORK);
        closed_r <= 1'b0;
        taken_r  <= stamp_we;
      end else if (state_r == trwm_pkg::ST_PASS) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.commit) begin
        closed_r <= 1'b1;
      end
      if (stamp_we) begin
        fill_r <= fill_r + 1'b1;
        mask_r <= mask_r | (W'(1) << in_phase_id[trwm_pkg::MASK_SEL_W-1:0]);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_step_r   <= step_w;
      o_boot_r   <= boot_w;
      o_life_r   <= life_w;
      o_lwt_r    <= lwt_w;
      o_trend_r  <= trend_w;
      o_pct_r    <= pct_w;
      o_mask_r   <= mask_r;
      o_closed_r <= closed_r;
      o_taken_r  <= taken_r;
    end
  end

  trwm_bitpath u_bitpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .tok      (in_tokens),
    .wsteps   (wsteps_r),
    .life_val (cfg_data),
    .pct_val  (div_quot),
    .ge       (ge),
    .step_w   (step_w),
    .boot_w   (boot_w),
    .life_w   (life_w),
    .lwt_w    (lwt_w),
    .trend_w  (trend_w),
    .pct_w    (pct_w),
    .dvd_w    (dvd_w),
    .dvs_w    (dvs_w)
  );

  trwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dvd_w),
    .divisor  (dvs_w),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  trwm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk     (clk),
    .we      (stamp_we),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data ({in_phase_id, step_w}),
    .rd_addr (fill_r[ADDR_W-1:0]),
    .rd_data ()
  );

  assign out_valid         = out_valid_r;
  assign out_steps_count   = o_step_r;
  assign out_boot_tokens   = o_boot_r;
  assign out_life_tokens   = o_life_r;
  assign out_window_tokens = o_lwt_r;
  assign out_window_trend  = o_trend_r;
  assign out_idle_percent  = o_pct_r;
  assign out_phase_mask    = o_mask_r;
  assign out_window_closed = o_closed_r;
  assign out_stamp_taken   = o_taken_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(STAMP_DEPTH))
    else $error("stamp fill beyond table depth");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == trwm_pkg::ST_DIV))
    else $error("divider running outside divide state");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trwm_pkg::ST_IDLE) |=> ($stable(step_w) && $stable(boot_w)))
    else $error("counters moved while idle");

  a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stamp_we |=> $stable(mask_r))
    else $error("phase mask changed without a stored stamp");

endmodule
